// ===== src/sbsh_pkg.sv =====
// Shared types, constants and round table for the SHA-256 byte stream hasher.
// Used by sbsh_ctrl, sbsh_datapath and the top level; no dependencies.
`default_nettype none

package sbsh_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned WORD_IDX_W  = $clog2(DIGEST_WORDS);
  localparam int unsigned LEN_START   = 56;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam logic [31:0] IV [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_START,
    ST_PAD,
    ST_COMP_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LENGTH
  } byte_sel_t;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_EXTRA,
    BLK_FINAL
  } blk_kind_t;

  typedef struct packed {
    logic                  byte_wr;
    byte_sel_t             byte_sel;
    logic                  len_add;
    logic                  blk_add;
    logic                  work_load;
    logic                  round_en;
    logic [ROUND_W-1:0]    round_idx;
    logic                  chain_update;
    logic                  hash_init;
    logic [WORD_IDX_W-1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_lt56;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/sbsh_datapath.sv =====
// Datapath: byte packing, 16-word message schedule window, round unit,
// chaining value, bit count and digest word select. Uses sbsh_pkg.
`default_nettype none

module sbsh_datapath
  import sbsh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [7:0]  data_byte,
  output dp_status_t       status,
  output logic [31:0]      digest_word
);

  logic [31:0]       chain [DIGEST_WORDS];
  logic [31:0]       work  [DIGEST_WORDS];
  logic [31:0]       w     [16];
  logic [23:0]       acc;
  logic [FILL_W-1:0] fill;
  logic [63:0]       total;

  logic [7:0]  wr_byte;
  logic [2:0]  len_sel;
  logic [31:0] new_w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign len_sel = 3'd7 - fill[2:0];

  always_comb begin
    case (cmd.byte_sel)
      SEL_INPUT:  wr_byte = data_byte;
      SEL_PAD80:  wr_byte = PAD_BYTE;
      SEL_LENGTH: wr_byte = total[{len_sel, 3'b000} +: 8];
      default:    wr_byte = 8'h00;
    endcase
  end

  always_comb begin
    new_w = (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10)) + w[9] +
            (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[0];
    ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1  = work[7] + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25)) + ch +
          K_TABLE[cmd.round_idx] + w[0];
    t2  = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22)) + maj;
  end

  // chaining value, bit count and fill level
  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      for (int i = 0; i < DIGEST_WORDS; i++) chain[i] <= IV[i];
      total <= '0;
      fill  <= '0;
    end else begin
      if (cmd.chain_update) begin
        for (int i = 0; i < DIGEST_WORDS; i++) chain[i] <= chain[i] + work[i];
      end
      if (cmd.len_add) begin
        total <= total + {{(64 - FILL_W - 3){1'b0}}, fill, 3'b000};
      end else if (cmd.blk_add) begin
        total <= total + BLOCK_BITS;
      end
      if (cmd.byte_wr) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // byte packing and schedule window; a full word enters at the top
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      acc <= {acc[15:0], wr_byte};
      if (fill[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= {acc, wr_byte};
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      for (int i = 0; i < DIGEST_WORDS; i++) work[i] <= chain[i];
    end else if (cmd.round_en) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

  assign status.fill_last = (fill == FILL_W'(BLOCK_BYTES - 1));
  assign status.fill_lt56 = (fill < FILL_W'(LEN_START));
  assign digest_word      = chain[cmd.out_idx];

endmodule

`default_nettype wire

// ===== src/sbsh_ctrl.sv =====
// Controller FSM: input acceptance, padding sequence, round count and
// digest emission. Drives sbsh_datapath through dp_cmd_t. Uses sbsh_pkg.
`default_nettype none

module sbsh_ctrl
  import sbsh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  has_byte,
  input  wire logic                  end_of_message,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_IDX_W-1:0]      word_index,
  output logic                       last_word,
  input  wire dp_status_t            status,
  output dp_cmd_t                    cmd
);

  state_t                state, state_next;
  blk_kind_t             kind, kind_next;
  logic                  eom_pending, eom_pending_next;
  logic                  len_ok, len_ok_next;
  logic [ROUND_W-1:0]    rnd, rnd_next;
  logic [WORD_IDX_W-1:0] widx, widx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      kind        <= BLK_DATA;
      eom_pending <= 1'b0;
      len_ok      <= 1'b0;
      rnd         <= '0;
      widx        <= '0;
    end else begin
      state       <= state_next;
      kind        <= kind_next;
      eom_pending <= eom_pending_next;
      len_ok      <= len_ok_next;
      rnd         <= rnd_next;
      widx        <= widx_next;
    end
  end

  always_comb begin
    state_next       = state;
    kind_next        = kind;
    eom_pending_next = eom_pending;
    len_ok_next      = len_ok;
    rnd_next         = rnd;
    widx_next        = widx;
    cmd              = '0;
    cmd.byte_sel     = SEL_INPUT;
    cmd.round_idx    = rnd;
    cmd.out_idx      = widx;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.byte_wr = has_byte;
          if (has_byte && status.fill_last) begin
            kind_next        = BLK_DATA;
            eom_pending_next = end_of_message;
            state_next       = ST_COMP_LOAD;
          end else if (end_of_message) begin
            state_next = ST_PAD_START;
          end
        end
      end
      ST_PAD_START: begin
        // add the buffered bytes to the count and append the 0x80 marker
        cmd.byte_wr  = 1'b1;
        cmd.byte_sel = SEL_PAD80;
        cmd.len_add  = 1'b1;
        len_ok_next  = status.fill_lt56;
        eom_pending_next = 1'b0;
        if (status.fill_last) begin
          kind_next  = BLK_EXTRA;
          state_next = ST_COMP_LOAD;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd.byte_wr  = 1'b1;
        cmd.byte_sel = (len_ok && !status.fill_lt56) ? SEL_LENGTH : SEL_ZERO;
        if (status.fill_last) begin
          kind_next  = len_ok ? BLK_FINAL : BLK_EXTRA;
          state_next = ST_COMP_LOAD;
        end
      end
      ST_COMP_LOAD: begin
        cmd.work_load = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 1'b1;
        if (rnd == ROUND_W'(ROUNDS - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.chain_update = 1'b1;
        unique case (kind)
          BLK_DATA: begin
            cmd.blk_add = 1'b1;
            state_next  = eom_pending ? ST_PAD_START : ST_IDLE;
          end
          BLK_EXTRA: begin
            len_ok_next = 1'b1;
            state_next  = ST_PAD;
          end
          default: begin
            widx_next  = '0;
            state_next = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (!out_stall) begin
          widx_next = widx + 1'b1;
          if (widx == WORD_IDX_W'(DIGEST_WORDS - 1)) begin
            cmd.hash_init = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = (state == ST_EMIT);
  assign word_index = widx;
  assign last_word  = (widx == WORD_IDX_W'(DIGEST_WORDS - 1));

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == ROUND_W'(ROUNDS - 1)) |=> (state == ST_UPDATE))
    else $error("round counter did not close the compression");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (state == ST_IDLE && widx == '0))
    else $error("digest emission did not return to idle");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.byte_wr && (cmd.round_en || cmd.work_load || cmd.chain_update)))
    else $error("byte write during compression");

  a_final_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && kind == BLK_FINAL) |-> len_ok)
    else $error("final block closed without length field");

endmodule

`default_nettype wire

// ===== src/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte stream hasher, top level.
// Input channel: in_valid/in_stall with has_byte, data_byte, end_of_message.
//   A transfer takes place at a rising edge with in_valid high and in_stall low.
//   Each transfer may carry one message byte; end_of_message closes the message.
// Output channel: out_valid/out_stall with digest_word, word_index, last_word.
//   Eight transfers per message, word 0 first, last_word set on word 7.
// Throughput: one byte per cycle while a block fills. The 64th byte of a block
//   starts the compression: a load, 64 rounds on the single round unit and
//   a chaining update; in_stall stays high until the update is done.
// Closing a message: the pad marker, then zero fill and length bytes one per
//   cycle up to the end of the block, then the compression of that block;
//   with 56 or more bytes buffered a second padding block follows. The digest
//   words then appear one per cycle while out_stall stays low.
// in_stall is high whenever the hasher is not idle. While out_stall is high
//   the current digest word holds and nothing else advances.
// Reset (rst, synchronous) loads the initial hash and clears the count; the
//   hasher reinitializes the same way after the last digest word transfers.
// Depends on sbsh_pkg, sbsh_ctrl and sbsh_datapath.
`default_nettype none

module sha256_byte_stream_hasher_top
  import sbsh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        has_byte,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sbsh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_index     (word_index),
    .last_word      (last_word),
    .status         (status),
    .cmd            (cmd)
  );

  sbsh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher top level.
// Holds its own SHA-256 predictor and compares every digest word transfer.
// Needs only sha256_byte_stream_hasher_top and the files it pulls in.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned MIN_RANDOM_MSGS = 6;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        has_byte = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hasher_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .has_byte       (has_byte),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] bit_total;

  digest_out_t pending_words [$];

  bit          in_idle_on = 1'b0;
  bit          out_idle_on = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned msg_count = 0;
  int unsigned extra_pad_count = 0;
  int unsigned multi_block_count = 0;
  int unsigned words_checked = 0;
  int unsigned stall_left = 0;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void hash_init();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = SHA_H0[i];
    for (i = 0; i < 64; i++) msg_block[i] = 8'h00;
    block_fill = 0;
    bit_total = 64'd0;
  endfunction

  function automatic void compress_block_model();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  // advance the predictor by one accepted item, queue the digest on a close
  function automatic void predict_digest(input logic hb, input logic [7:0] db,
                                         input logic eom);
    int unsigned pos;
    int i;
    digest_out_t d;
    if (hb) begin
      msg_block[block_fill] = db;
      block_fill++;
      if (block_fill == 64) begin
        compress_block_model();
        bit_total += 64'd512;
        block_fill = 0;
      end
    end
    if (!eom) return;
    if (bit_total != 0) multi_block_count++;
    pos = block_fill;
    bit_total += 64'(pos) * 64'd8;
    msg_block[pos] = 8'h80;
    pos++;
    // no room for the length field: pad out and spend an extra block
    if (pos > 56) begin
      extra_pad_count++;
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block_model();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) msg_block[56+i] = bit_total[63-8*i -: 8];
    compress_block_model();
    for (i = 0; i < 8; i++) begin
      d.word = hash_state[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      pending_words.push_back(d);
    end
    msg_count++;
    hash_init();
  endfunction

  task automatic push_item(input logic hb, input logic [7:0] db, input logic eom);
    int unsigned gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    has_byte <= hb;
    data_byte <= db;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(hb, db, eom);
    if (hb || eom) items_sent++;
    if (hb) bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit close_on_byte);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) push_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      push_item(1'b1, 8'($urandom_range(0, 255)), close_on_byte && (i == len - 1));
    end
    if (len == 0 || !close_on_byte) push_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_message();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    push_item(1'b0, 8'h00, 1'b0);
    push_item(1'b0, 8'hff, 1'b0);
    push_item(1'b0, 8'h00, 1'b1);
    // second close right behind the first: empty message again
    push_item(1'b0, 8'ha5, 1'b1);
  endtask

  task automatic test_short_messages();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h62, 1'b0);
    push_item(1'b1, 8'h63, 1'b1);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    push_item(1'b1, 8'h00, 1'b1);
    push_item(1'b1, 8'hff, 1'b1);
    // empty item mid message, then a close with no byte
    push_item(1'b1, 8'h55, 1'b0);
    push_item(1'b0, 8'hff, 1'b0);
    push_item(1'b1, 8'haa, 1'b0);
    push_item(1'b0, 8'h00, 1'b1);
  endtask

  task automatic test_drain_pause();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    push_item(1'b1, 8'h3c, 1'b0);
    push_item(1'b1, 8'hc3, 1'b1);
    wait_drained();
    push_item(1'b1, 8'h7e, 1'b0);
    push_item(1'b0, 8'h81, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned start_items;
    int unsigned start_msgs;
    int unsigned r;
    int unsigned len;
    int unsigned near_block [6];
    near_block = '{55, 56, 57, 63, 64, 65};
    start_items = items_sent;
    start_msgs = msg_count;
    while (items_sent - start_items < RANDOM_ITEMS ||
           msg_count - start_msgs < MIN_RANDOM_MSGS) begin
      r = $urandom_range(0, 99);
      if (r < 45) len = $urandom_range(0, 12);
      else if (r < 80) len = near_block[$urandom_range(0, 5)];
      else len = $urandom_range(13, 130);
      // some messages go through with no idling on either side
      in_idle_on = ($urandom_range(0, 99) >= 15);
      out_idle_on = in_idle_on;
      send_message(len, (len > 0) && ($urandom_range(0, 1) == 1));
      if ($urandom_range(0, 99) < 15) wait_drained();
    end
  endtask

  function automatic void flag_error(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("ERROR cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
  endfunction

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin : check_words
    digest_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("simulation failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        flag_error("unexpected digest word", 32'h0, digest_word);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (digest_word !== want.word) flag_error("digest_word", want.word, digest_word);
        if (word_index !== want.idx)
          flag_error("word_index", 32'(want.idx), 32'(word_index));
        if (last_word !== want.last)
          flag_error("last_word", 32'(want.last), 32'(last_word));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  initial begin
    hash_init();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_short_messages();
    test_drain_pause();
    test_random_messages();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d items, %0d bytes, %0d messages, %0d digest words checked",
             items_sent, bytes_sent, msg_count, words_checked);
    $display("     %0d closes needing an extra pad block, %0d messages over one block",
             extra_pad_count, multi_block_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
